/* sv/pda_pkg.sv */
`timescale 1ns / 1ps
// Package for the palette allocator: item structs, opcode and result kind codes,
// sizing constants and the controller state type. Has no dependencies.
package pda_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int LINE_WIDTH      = 640;
  localparam int FRAME_HEIGHT    = 480;

  // The key store has room for 256 keys. Indexes are 8 bits wide and the use count is 9 bits.
  localparam int STORE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int USED_W      = 9;
  localparam int KEY_W       = 12;

  localparam logic [2:0] OP_PAL_RESET = 3'd0;
  localparam logic [2:0] OP_ALLOC     = 3'd1;
  localparam logic [2:0] OP_PIXEL     = 3'd2;
  localparam logic [2:0] OP_FILL      = 3'd3;
  localparam logic [2:0] OP_SWAP      = 3'd4;

  localparam logic [2:0] KIND_INDEX  = 3'd0;
  localparam logic [2:0] KIND_PWRITE = 3'd1;
  localparam logic [2:0] KIND_PIXEL  = 3'd2;
  localparam logic [2:0] KIND_FILL   = 3'd3;
  localparam logic [2:0] KIND_SWAP   = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] row;
    logic [10:0] column;
    logic [11:0] fill_count;
  } pda_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  color_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_row;
    logic [10:0] out_column;
    logic [11:0] out_count;
    logic        last;
  } pda_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MISS,
    S_PWRITE,
    S_FINAL
  } pda_state_t;

endpackage

/* sv/pda_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies.
module pda_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/palette_dedup_allocator_core.sv */
`timescale 1ns / 1ps
// Top level of the palette allocator: controller, key search and the result register.
// Depends on pda_pkg and pda_ram.
//
//   channel | signals                 | direction | carries
//   --------+-------------------------+-----------+----------------------------------
//   command | cmd_valid, cmd_ready, cmd | in      | opcode, color, row, column, count
//   result  | res_valid, res_ready, res | out     | kind, index, color, row, col, count
//
// The block handles one item at a time. Swap frame emits only its final result; palette
// reset, dropped pixels and unused opcodes emit nothing. An allocating item searches
// the stored keys, appends its key and emits a palette write on a miss with room left,
// and then emits its final result. The search compares one stored key at a time, since
// the single read port of the key memory returns one key each cycle.
// rst is synchronous. It empties the palette and clears the controller and the
// result valid flag. The key memory is not cleared, because only entries below the use
// count are ever compared. A stalled result port holds the controller in its emit states.
// A new item can still be taken while the last result of the item before waits.
module palette_dedup_allocator_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  pda_pkg::pda_in_t cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output pda_pkg::pda_out_t res
);
  import pda_pkg::*;

  pda_state_t          state;
  pda_state_t          state_next;
  pda_in_t             item;          // accepted item, fill count already clamped
  logic [IDX_W-1:0]    ptr;           // entry whose key is on the RAM read port
  logic [IDX_W-1:0]    idx;           // index to report
  logic [USED_W-1:0]   entries_used;

  logic [KEY_W-1:0]    item_key;
  logic [KEY_W-1:0]    rd_key;
  logic [IDX_W-1:0]    rd_addr;
  logic                ram_we;
  logic                accept;
  logic                slot_free;
  logic                res_load;
  pda_out_t            res_next;
  logic                key_hit;
  logic                last_key;
  logic                full;
  logic                in_range;
  logic                cmd_empty;
  pda_in_t             cmd_clamped;

  assign item_key  = {item.red[3:0], item.green[3:0], item.blue[3:0]};
  assign accept    = cmd_valid && cmd_ready;
  assign slot_free = !res_valid || res_ready;
  assign key_hit   = (rd_key == item_key);
  assign last_key  = (({1'b0, ptr} + USED_W'(1)) == entries_used);
  assign full      = (entries_used >= USED_W'(PALETTE_ENTRIES));
  assign cmd_empty = (entries_used == '0);
  // Columns and rows are compared at 12 bits because the limits may reach 2048.
  assign in_range  = ({1'b0, cmd.column} < 12'(LINE_WIDTH)) &&
                     ({1'b0, cmd.row} < 12'(FRAME_HEIGHT));

  // The fill count is saturated to the line width before the item is stored.
  always_comb begin
    cmd_clamped = cmd;
    if (cmd.fill_count > 12'(LINE_WIDTH)) begin
      cmd_clamped.fill_count = 12'(LINE_WIDTH);
    end
  end

  // The search reads one entry ahead. Key 0 is requested in the cycle the item is
  // accepted, so its data is ready in the first search cycle.
  assign rd_addr = (state == S_SEARCH) ? ptr + IDX_W'(1) : '0;
  assign ram_we  = (state == S_MISS) && !full;

  pda_ram #(
    .WIDTH(KEY_W),
    .DEPTH(STORE_DEPTH)
  ) u_key_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entries_used[IDX_W-1:0]),
    .wdata(item_key),
    .raddr(rd_addr),
    .rdata(rd_key)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.opcode)
            OP_ALLOC, OP_FILL: state_next = cmd_empty ? S_MISS : S_SEARCH;
            OP_PIXEL: begin
              if (in_range) begin
                state_next = cmd_empty ? S_MISS : S_SEARCH;
              end
            end
            OP_SWAP: state_next = S_FINAL;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (key_hit) begin
          state_next = S_FINAL;
        end else if (last_key) begin
          state_next = S_MISS;
        end
      end
      S_MISS:   state_next = full ? S_FINAL : S_PWRITE;
      S_PWRITE: if (slot_free) state_next = S_FINAL;
      S_FINAL:  if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the controller: handshake and the result to load.
  always_comb begin
    cmd_ready = (state == S_IDLE);
    res_load  = 1'b0;
    res_next  = '0;
    unique case (state)
      S_PWRITE: begin
        res_load             = slot_free;
        res_next.kind        = KIND_PWRITE;
        res_next.color_index = idx;
        res_next.out_red     = item.red;
        res_next.out_green   = item.green;
        res_next.out_blue    = item.blue;
      end
      S_FINAL: begin
        res_load             = slot_free;
        res_next.last        = 1'b1;
        res_next.color_index = idx;
        unique case (item.opcode)
          OP_ALLOC: res_next.kind = KIND_INDEX;
          OP_PIXEL: begin
            res_next.kind       = KIND_PIXEL;
            res_next.out_row    = item.row;
            res_next.out_column = item.column;
          end
          OP_FILL: begin
            res_next.kind      = KIND_FILL;
            res_next.out_row   = item.row;
            res_next.out_count = item.fill_count;
          end
          default: begin
            res_next.kind        = KIND_SWAP;
            res_next.color_index = '0;
          end
        endcase
      end
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entries_used <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && cmd.opcode == OP_PAL_RESET) begin
        entries_used <= '0;
      end else if (ram_we) begin
        entries_used <= entries_used + USED_W'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd_clamped;
      ptr <= '0;
      idx <= '0;
    end else if (state == S_SEARCH) begin
      if (key_hit) begin
        idx <= ptr;
      end else begin
        ptr <= ptr + IDX_W'(1);
      end
    end else if (state == S_MISS) begin
      idx <= full ? '0 : entries_used[IDX_W-1:0];
    end
    if (res_load) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= USED_W'(PALETTE_ENTRIES))
    else $error("palette use count above palette size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || res_ready))
    else $error("pending result overwritten");

  a_search_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ({1'b0, ptr} < entries_used))
    else $error("search beyond keys in use");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_MISS && !full) |=> (entries_used == $past(entries_used) + USED_W'(1)))
    else $error("append did not advance use count");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for palette_dedup_allocator_core: a palette tracker predicts every
// command the block should emit and checks each one as it leaves the result port.
// Depends on pda_pkg and the RTL of the block.
module testbench;
  import pda_pkg::*;

  // Opcodes 5 to 7 have no meaning; the block must swallow them silently.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 300;

  // Tracks the palette contents the way the block should, and holds the
  // commands that the block still owes for the items it has taken.
  class palette_tracker;
    logic [KEY_W-1:0]  keys [STORE_DEPTH];
    logic [USED_W-1:0] used;
    pda_out_t owed_commands [$];
    int errors, results_seen, palette_writes, full_misses, dropped, ignored, peak_used;

    function new();
      used = '0;
      errors = 0;
      results_seen = 0;
      palette_writes = 0;
      full_misses = 0;
      dropped = 0;
      ignored = 0;
      peak_used = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
      errors++;
    endtask

    // Searches the keys in allocation order; on a miss with room left, appends
    // the key and owes a palette entry write ahead of the final command.
    function logic [IDX_W-1:0] find_or_append(input pda_in_t c);
      logic [KEY_W-1:0] key;
      pda_out_t wr;
      key = {c.red[3:0], c.green[3:0], c.blue[3:0]};
      for (int i = 0; i < used; i++) begin
        if (keys[i] == key) return i[IDX_W-1:0];
      end
      if (used >= PALETTE_ENTRIES) begin
        full_misses++;
        return '0;
      end
      keys[used[IDX_W-1:0]] = key;
      wr = '0;
      wr.kind = KIND_PWRITE;
      wr.color_index = used[IDX_W-1:0];
      wr.out_red = c.red;
      wr.out_green = c.green;
      wr.out_blue = c.blue;
      owed_commands.push_back(wr);
      palette_writes++;
      used++;
      if (int'(used) > peak_used) peak_used = int'(used);
      return wr.color_index;
    endfunction

    function void accept_request(input pda_in_t c);
      pda_out_t fin;
      fin = '0;
      fin.last = 1'b1;
      case (c.opcode)
        OP_PAL_RESET: used = '0;
        OP_ALLOC: begin
          fin.color_index = find_or_append(c);
          fin.kind = KIND_INDEX;
          owed_commands.push_back(fin);
        end
        OP_PIXEL: begin
          // Out-of-range pixels vanish before the palette is touched.
          if (c.column >= LINE_WIDTH || c.row >= FRAME_HEIGHT) begin
            dropped++;
          end else begin
            fin.color_index = find_or_append(c);
            fin.kind = KIND_PIXEL;
            fin.out_row = c.row;
            fin.out_column = c.column;
            owed_commands.push_back(fin);
          end
        end
        OP_FILL: begin
          fin.color_index = find_or_append(c);
          fin.kind = KIND_FILL;
          fin.out_row = c.row;
          fin.out_count = (c.fill_count > LINE_WIDTH) ? 12'(LINE_WIDTH) : c.fill_count;
          owed_commands.push_back(fin);
        end
        OP_SWAP: begin
          fin.kind = KIND_SWAP;
          owed_commands.push_back(fin);
        end
        default: ignored++;
      endcase
    endfunction

    task compare(input string field, input logic [11:0] got, input logic [11:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task check_command(input pda_out_t got);
      pda_out_t want;
      results_seen++;
      if (owed_commands.size() == 0) begin
        report($sformatf("command of kind %0d with nothing owed", got.kind));
        return;
      end
      want = owed_commands.pop_front();
      compare("kind", 12'(got.kind), 12'(want.kind));
      compare("color_index", 12'(got.color_index), 12'(want.color_index));
      compare("out_red", 12'(got.out_red), 12'(want.out_red));
      compare("out_green", 12'(got.out_green), 12'(want.out_green));
      compare("out_blue", 12'(got.out_blue), 12'(want.out_blue));
      compare("out_row", 12'(got.out_row), 12'(want.out_row));
      compare("out_column", 12'(got.out_column), 12'(want.out_column));
      compare("out_count", got.out_count, want.out_count);
      compare("last", 12'(got.last), 12'(want.last));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  pda_in_t  cmd = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  pda_out_t res;

  palette_tracker tracker;
  bit calm = 1'b0;           // both sides run without idling while set
  bit long_hold_due = 1'b0;  // asks the receiver for one long stall
  int items_sent = 0;
  logic [KEY_W-1:0] filled_key [STORE_DEPTH];

  palette_dedup_allocator_core dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: checks accepted commands and decides ready for the next edge.
  // The long stall is counted here so that the sender keeps offering items
  // and the block backs up into its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) tracker.check_command(res);
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
        res_ready <= 1'b0;
      end else begin
        res_ready <= calm || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  function automatic pda_in_t make_item(input logic [2:0] op, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [10:0] row, input logic [10:0] col,
                                        input logic [11:0] cnt);
    pda_in_t c;
    c.opcode = op;
    c.red = r;
    c.green = g;
    c.blue = b;
    c.row = row;
    c.column = col;
    c.fill_count = cnt;
    return c;
  endfunction

  // Places a 12-bit key in the low nibbles; the high nibbles are noise the
  // block must ignore for matching but pass on in palette writes.
  function automatic pda_in_t with_key(input pda_in_t c, input logic [KEY_W-1:0] key);
    c.red = {4'($urandom_range(0, 15)), key[11:8]};
    c.green = {4'($urandom_range(0, 15)), key[7:4]};
    c.blue = {4'($urandom_range(0, 15)), key[3:0]};
    return c;
  endfunction

  function automatic pda_in_t random_item(input bit allow_reset, input bit known_keys);
    pda_in_t c;
    int pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    c.row = 11'($urandom_range(0, 2047));
    c.column = 11'($urandom_range(0, 2047));
    c.fill_count = 12'($urandom_range(0, 4095));
    if (pick < 3 && allow_reset) c.opcode = OP_PAL_RESET;
    else if (pick < 5) c.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else if (pick < 12) c.opcode = OP_SWAP;
    else if (pick < 45) c.opcode = OP_ALLOC;
    else if (pick < 72) c.opcode = OP_PIXEL;
    else c.opcode = OP_FILL;
    if (c.opcode == OP_PIXEL && $urandom_range(0, 99) < 85) begin
      c.row = 11'($urandom_range(0, FRAME_HEIGHT - 1));
      c.column = 11'($urandom_range(0, LINE_WIDTH - 1));
    end
    if (c.opcode == OP_FILL && $urandom_range(0, 99) < 60) begin
      c.fill_count = 12'($urandom_range(0, LINE_WIDTH));
    end
    // A small key pool makes hits common; known keys hit a full palette.
    if (known_keys && $urandom_range(0, 1) == 1) key = filled_key[8'($urandom_range(0, 255))];
    else if ($urandom_range(0, 99) < 60) key = 12'($urandom_range(0, 47));
    else key = 12'($urandom_range(0, 4095));
    return with_key(c, key);
  endfunction

  task automatic send(input pda_in_t c);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 19) gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    tracker.accept_request(c);
    items_sent++;
  endtask

  // Stops offering items until every owed command has come back.
  task automatic drain(input int settle);
    int waited;
    waited = 0;
    cmd_valid <= 1'b0;
    while (tracker.owed_commands.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.owed_commands.size() != 0) begin
      tracker.report($sformatf("%0d commands never arrived",
                               tracker.owed_commands.size()));
      tracker.owed_commands.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    pda_in_t directed [$];
    pda_in_t c;
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: every defined opcode, unused opcodes 5 and 7, field extremes, drops, clamping and reuse after reset.
    directed.push_back(make_item(OP_SWAP, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 11'h7FF,
                                 12'hFFF));
    directed.push_back(make_item(OP_UNUSED_HI, 8'h12, 8'h34, 8'h56, 11'd3, 11'd4, 12'd5));
    directed.push_back(make_item(OP_ALLOC, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 11'h7FF, 12'hFFF));
    directed.push_back(make_item(OP_ALLOC, 8'h0F, 8'h0F, 8'h0F, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_ALLOC, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_ALLOC, 8'hA5, 8'h5A, 8'hC3, 11'd1, 11'd2, 12'd3));
    directed.push_back(make_item(OP_PIXEL, 8'hF0, 8'hF0, 8'hF0, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_PIXEL, 8'h12, 8'h34, 8'h56, 11'd479, 11'd639, 12'd0));
    directed.push_back(make_item(OP_PIXEL, 8'h77, 8'h88, 8'h99, 11'd480, 11'd0, 12'd0));
    directed.push_back(make_item(OP_PIXEL, 8'h77, 8'h88, 8'h99, 11'd0, 11'd640, 12'd0));
    directed.push_back(make_item(OP_PIXEL, 8'h77, 8'h88, 8'h99, 11'h7FF, 11'h7FF,
                                 12'hFFF));
    // The colors of the dropped pixels must not have been allocated.
    directed.push_back(make_item(OP_ALLOC, 8'h07, 8'h08, 8'h09, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_FILL, 8'h0F, 8'hFF, 8'h0F, 11'h7FF, 11'd0, 12'hFFF));
    directed.push_back(make_item(OP_FILL, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 12'd640));
    directed.push_back(make_item(OP_FILL, 8'h00, 8'h00, 8'h00, 11'd5, 11'h7FF, 12'd641));
    directed.push_back(make_item(OP_FILL, 8'h31, 8'h32, 8'h33, 11'd6, 11'd0, 12'd0));
    directed.push_back(make_item(OP_FILL, 8'h31, 8'h32, 8'h33, 11'd7, 11'd0, 12'd639));
    directed.push_back(make_item(OP_PAL_RESET, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 11'h7FF,
                                 12'hFFF));
    directed.push_back(make_item(OP_ALLOC, 8'h12, 8'h34, 8'h56, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_PAL_RESET, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_PAL_RESET, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_ALLOC, 8'h80, 8'h40, 8'h20, 11'd0, 11'd0, 12'd0));
    directed.push_back(make_item(OP_SWAP, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 11'h7FF, 12'hFFF));
    foreach (directed[i]) send(directed[i]);
    drain(SETTLE_CYCLES);

    // Mixed traffic on a small palette, opened by one long receiver stall.
    long_hold_due = 1'b1;
    repeat (250) send(random_item(1'b1, 1'b0));
    drain(SETTLE_CYCLES);

    // Fill the palette with 256 distinct keys through all allocating opcodes.
    send(make_item(OP_PAL_RESET, 8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 12'd0));
    for (int i = 0; i < STORE_DEPTH; i++) begin
      c = random_item(1'b0, 1'b0);
      case ($urandom_range(0, 2))
        0: c.opcode = OP_ALLOC;
        1: begin
          c.opcode = OP_PIXEL;
          c.row = 11'($urandom_range(0, FRAME_HEIGHT - 1));
          c.column = 11'($urandom_range(0, LINE_WIDTH - 1));
        end
        default: c.opcode = OP_FILL;
      endcase
      filled_key[i] = {i[7:4], i[3:0], 4'($urandom_range(0, 15))};
      send(with_key(c, filled_key[i]));
    end

    // Full palette: misses give index 0 with no write, hits search deep.
    repeat (80) send(random_item(1'b0, 1'b1));
    drain(SETTLE_CYCLES);

    // More mixed traffic, with a stretch where neither side idles.
    for (int i = 0; i < 250; i++) begin
      calm = (i >= 100 && i < 200);
      send(random_item(1'b1, 1'b0));
    end
    calm = 1'b0;
    drain(SETTLE_CYCLES);

    $display("Run covered %0d items and %0d commands: %0d palette writes, %0d full misses,",
             items_sent, tracker.results_seen, tracker.palette_writes, tracker.full_misses);
    $display("%0d dropped pixels, %0d unused opcodes, palette peak %0d entries.",
             tracker.dropped, tracker.ignored, tracker.peak_used);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
